// File: design/ps2mpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mpd_pkg
// Shared types, constants and helpers of the PS/2 mouse packet decoder.
// ----------------------------------------------------------------------------
package ps2mpd_pkg;

  // Configuration port geometry
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 13;

  // Field widths
  localparam int ScreenW = 13;
  localparam int PosW    = 14;
  localparam int AbsW    = 9;
  localparam int ProdW   = AbsW + ScreenW;
  localparam int CountW  = 16;

  // Bit positions inside the first (flags) byte of a packet
  localparam int BitLeft   = 0;
  localparam int BitRight  = 1;
  localparam int BitMiddle = 2;
  localparam int BitSync   = 3;
  localparam int BitSignX  = 4;
  localparam int BitSignY  = 5;
  localparam int BitOvfX   = 6;
  localparam int BitOvfY   = 7;

  // Packet byte positions
  localparam logic [1:0] PosFlags = 2'd0;
  localparam logic [1:0] PosDx    = 2'd1;
  localparam logic [1:0] PosDy    = 2'd2;
  localparam logic [1:0] PosWheel = 2'd3;

  // Wheel step codes
  localparam logic signed [1:0] WheelUp   = 2'sb01;
  localparam logic signed [1:0] WheelDown = 2'sb11;
  localparam logic signed [1:0] WheelNone = 2'sb00;

  localparam logic [CountW-1:0] CountMax = '1;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_ABS_MODE      = 2'd0,
    REG_SCROLL_EN     = 2'd1,
    REG_SCREEN_WIDTH  = 2'd2,
    REG_SCREEN_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic               abs_mode;
    logic               scroll_en;
    logic [ScreenW-1:0] screen_width;
    logic [ScreenW-1:0] screen_height;
  } cfg_t;

  // Report between assembler and scaler; raw_* hold the product in
  // absolute mode and the finished value in the low bits otherwise.
  typedef struct packed {
    logic [ProdW-1:0]  raw_x;
    logic [ProdW-1:0]  raw_y;
    logic              is_abs;
    logic              btn_left;
    logic              btn_right;
    logic              btn_middle;
    logic signed [1:0] wheel;
    logic [CountW-1:0] sync_losses;
  } stage_t;

  // Floor division by 511 = 2^9 - 1 using shifts and adds.
  // p = 511*q1 + r1, r1 = 511*q2 + r2, r2 < 528 needs one correction.
  function automatic logic [PosW-1:0] div511(input logic [ProdW-1:0] p);
    logic [12:0] q1;
    logic [13:0] r1;
    logic [4:0]  q2;
    logic [9:0]  r2;
    logic        fix;
    q1  = p[21:9];
    r1  = {5'b0, p[8:0]} + {1'b0, q1};
    q2  = r1[13:9];
    r2  = {1'b0, r1[8:0]} + {5'b0, q2};
    fix = (r2 >= 10'd511);
    return {1'b0, q1} + {9'b0, q2} + {13'b0, fix};
  endfunction

endpackage

// File: design/ps2mpd_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mpd_byte_if
// Valid/ready channel carrying one received mouse byte per transaction.
// ----------------------------------------------------------------------------
interface ps2mpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: design/ps2mpd_report_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mpd_report_if
// Valid/ready channel carrying one decoded mouse report per transaction.
// ----------------------------------------------------------------------------
interface ps2mpd_report_if;
  logic               valid;
  logic               ready;
  logic signed [13:0] pos_x;
  logic signed [13:0] pos_y;
  logic               button_left;
  logic               button_right;
  logic               button_middle;
  logic signed [1:0]  wheel_step;
  logic               is_absolute;
  logic [15:0]        sync_losses;

  modport source (
    output valid, output pos_x, output pos_y, output button_left,
    output button_right, output button_middle, output wheel_step,
    output is_absolute, output sync_losses, input ready
  );
  modport sink (
    input valid, input pos_x, input pos_y, input button_left,
    input button_right, input button_middle, input wheel_step,
    input is_absolute, input sync_losses, output ready
  );
endinterface

// File: design/ps2mpd_assembler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mpd_assembler
// Input byte register, packet framing state, sync-loss counter and the
// report stage holding buttons, wheel and the position products.
// ----------------------------------------------------------------------------
module ps2mpd_assembler (
  input  logic                 clk,
  input  logic                 rst,
  ps2mpd_byte_if.sink          bytes,
  input  ps2mpd_pkg::cfg_t     cfg,
  output logic                 s2_valid,
  output ps2mpd_pkg::stage_t   s2_data,
  input  logic                 s2_take
);
  import ps2mpd_pkg::*;

  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              s1_ready;
  logic              s2_ready;
  logic              s1_fire;

  logic [1:0]        byte_pos;
  logic [1:0]        byte_pos_next;
  logic [7:0]        store [3];
  logic [7:0]        store_next [3];
  logic [CountW-1:0] lost_count;

  logic              drop;
  logic              done;
  logic              emit;
  logic [7:0]        flags;
  logic signed [1:0] wheel;
  logic [AbsW-1:0]   ax;
  logic [AbsW-1:0]   ay;
  logic [ProdW-1:0]  prod_x;
  logic [ProdW-1:0]  prod_y;
  logic [PosW-1:0]   rel_x;
  logic [PosW-1:0]   rel_y;
  stage_t            stage;

  // Handshake chain
  assign s2_ready    = !s2_valid || s2_take;
  assign s1_ready    = !s1_valid || s2_ready;
  assign s1_fire     = s1_valid && s2_ready;
  assign bytes.ready = s1_ready;

  // Input byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= bytes.valid;
    end
    if (bytes.valid && s1_ready) begin
      s1_byte <= bytes.rx_byte;
    end
  end

  // Framing: drop unsynced first bytes, store bytes 0..2, detect packet end
  always_comb begin
    drop = (byte_pos == PosFlags) && !s1_byte[BitSync];
    for (int i = 0; i < 3; i++) begin
      store_next[i] = (!drop && byte_pos == 2'(i)) ? s1_byte : store[i];
    end
    done = !drop && ((byte_pos == PosWheel) ||
                     (byte_pos == PosDy && !cfg.scroll_en));
    if (drop || done) begin
      byte_pos_next = PosFlags;
    end else begin
      byte_pos_next = byte_pos + 2'd1;
    end
    flags = store_next[0];
    emit  = done && !flags[BitOvfX] && !flags[BitOvfY];
  end

  // Wheel step from the signed Z nibble, negated and clamped
  always_comb begin
    wheel = WheelNone;
    if (cfg.scroll_en) begin
      case (s1_byte[3:0]) inside
        [4'd1:4'd7]:  wheel = WheelDown;
        [4'd8:4'd15]: wheel = WheelUp;
        default:      wheel = WheelNone;
      endcase
    end
  end

  // Position: products for absolute mode, sign-extended deltas otherwise
  always_comb begin
    ax     = {flags[BitSignX], store_next[1]};
    ay     = {flags[BitSignY], store_next[2]};
    prod_x = ProdW'(ax) * ProdW'(cfg.screen_width);
    prod_y = ProdW'(ay) * ProdW'(cfg.screen_height);
    rel_x  = {{(PosW-AbsW){ax[AbsW-1]}}, ax};
    rel_y  = PosW'(0) - {{(PosW-AbsW){ay[AbsW-1]}}, ay};

    stage.raw_x       = cfg.abs_mode ? prod_x : ProdW'(rel_x);
    stage.raw_y       = cfg.abs_mode ? prod_y : ProdW'(rel_y);
    stage.is_abs      = cfg.abs_mode;
    stage.btn_left    = flags[BitLeft];
    stage.btn_right   = flags[BitRight];
    stage.btn_middle  = flags[BitMiddle];
    stage.wheel       = wheel;
    stage.sync_losses = lost_count;
  end

  // Framing state and loss counter
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos   <= PosFlags;
      lost_count <= '0;
    end else if (s1_fire) begin
      byte_pos <= byte_pos_next;
      if (drop && lost_count != CountMax) begin
        lost_count <= lost_count + 1'b1;
      end
    end
  end

  // Packet bytes hold no reset: each is written before it is read
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      for (int i = 0; i < 3; i++) begin
        store[i] <= store_next[i];
      end
    end
  end

  // Report stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid && emit;
    end
    if (s1_fire && emit) begin
      s2_data <= stage;
    end
  end

endmodule

// File: design/ps2mpd_scaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mpd_scaler
// Output register: divides absolute products by 511 and presents reports.
// ----------------------------------------------------------------------------
module ps2mpd_scaler (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s2_valid,
  input  ps2mpd_pkg::stage_t   s2_data,
  output logic                 s2_take,
  ps2mpd_report_if.source      reports
);
  import ps2mpd_pkg::*;

  logic              out_valid;
  logic [PosW-1:0]   pos_x;
  logic [PosW-1:0]   pos_y;
  logic [PosW-1:0]   pos_x_next;
  logic [PosW-1:0]   pos_y_next;
  logic              btn_left;
  logic              btn_right;
  logic              btn_middle;
  logic signed [1:0] wheel;
  logic              is_abs;
  logic [CountW-1:0] losses;

  assign s2_take = !out_valid || reports.ready;

  // Scale to screen size in absolute mode
  assign pos_x_next = s2_data.is_abs ? div511(s2_data.raw_x) : s2_data.raw_x[PosW-1:0];
  assign pos_y_next = s2_data.is_abs ? div511(s2_data.raw_y) : s2_data.raw_y[PosW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_take) begin
      out_valid <= s2_valid;
    end
    if (s2_take && s2_valid) begin
      pos_x      <= pos_x_next;
      pos_y      <= pos_y_next;
      btn_left   <= s2_data.btn_left;
      btn_right  <= s2_data.btn_right;
      btn_middle <= s2_data.btn_middle;
      wheel      <= s2_data.wheel;
      is_abs     <= s2_data.is_abs;
      losses     <= s2_data.sync_losses;
    end
  end

  assign reports.valid         = out_valid;
  assign reports.pos_x         = signed'(pos_x);
  assign reports.pos_y         = signed'(pos_y);
  assign reports.button_left   = btn_left;
  assign reports.button_right  = btn_right;
  assign reports.button_middle = btn_middle;
  assign reports.wheel_step    = wheel;
  assign reports.is_absolute   = is_abs;
  assign reports.sync_losses   = losses;

endmodule

// File: design/ps2_mouse_packet_decoder.sv
`timescale 1ns / 1ps
// A report passes through the input register, the report stage and the output
// register in turn after the transaction that delivers the last byte of its
// packet. Throughput: one byte per cycle; the three stages pass items on
// independently, so only a stalled output holds up input.
// Reset: framing restarts at the first byte, the loss counter clears, and the
// configuration returns to relative mode, no wheel, 1024 x 768.
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder
// PS/2 mouse packet decoder with optional wheel byte and absolute scaling.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_decoder (
  input  logic                               clk,
  input  logic                               rst,
  ps2mpd_byte_if.sink                        bytes,
  ps2mpd_report_if.source                    reports,
  input  logic                               wr_en,
  input  logic [ps2mpd_pkg::CfgIdxW-1:0]     wr_index,
  input  logic [ps2mpd_pkg::CfgDataW-1:0]    wr_data
);
  import ps2mpd_pkg::*;

  cfg_t   cfg;
  logic   s2_valid;
  stage_t s2_data;
  logic   s2_take;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.abs_mode      <= 1'b0;
      cfg.scroll_en     <= 1'b0;
      cfg.screen_width  <= ScreenW'(1024);
      cfg.screen_height <= ScreenW'(768);
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_ABS_MODE:      cfg.abs_mode      <= wr_data[0];
        REG_SCROLL_EN:     cfg.scroll_en     <= wr_data[0];
        REG_SCREEN_WIDTH:  cfg.screen_width  <= wr_data[ScreenW-1:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= wr_data[ScreenW-1:0];
        default: ;
      endcase
    end
  end

  ps2mpd_assembler u_assembler (
    .clk      (clk),
    .rst      (rst),
    .bytes    (bytes),
    .cfg      (cfg),
    .s2_valid (s2_valid),
    .s2_data  (s2_data),
    .s2_take  (s2_take)
  );

  ps2mpd_scaler u_scaler (
    .clk      (clk),
    .rst      (rst),
    .s2_valid (s2_valid),
    .s2_data  (s2_data),
    .s2_take  (s2_take),
    .reports  (reports)
  );

  // Input backpressure only when every stage is full behind a stalled output
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !bytes.ready |-> (reports.valid && !reports.ready))
    else $error("input stalled without output backpressure");

  // Relative dx spans -256..255, negated dy spans -255..256
  a_rel_range: assert property (@(posedge clk) disable iff (rst)
    (reports.valid && !reports.is_absolute) |->
      (reports.pos_x >= -14'sd256) && (reports.pos_x <= 14'sd255) &&
      (reports.pos_y >= -14'sd255) && (reports.pos_y <= 14'sd256))
    else $error("relative position out of range");

  // Absolute positions are never negative
  a_abs_sign: assert property (@(posedge clk) disable iff (rst)
    (reports.valid && reports.is_absolute) |->
      (!reports.pos_x[13] && !reports.pos_y[13]))
    else $error("absolute position negative");

  // Wheel step is -1, 0 or +1
  a_wheel_code: assert property (@(posedge clk) disable iff (rst)
    reports.valid |-> (reports.wheel_step != 2'sb10))
    else $error("invalid wheel step");

endmodule
